### rtl/kvt_pkg.sv
// kvt_pkg: shared widths, codes and types of the direct-mapped key/value table
// no dependencies; imported by every other file of the block
`default_nettype none

package kvt_pkg;

    localparam int KEY_W       = 31;
    localparam int VAL_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int SLOT_IDX_W  = 8;
    localparam int LEN_W       = 5;
    localparam int SIZE_W      = 9;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    localparam int DEF_SLOTS           = 256;
    localparam int DEF_VALUES_PER_SLOT = 16;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_NEW     = 2'd0,
        STATUS_APPEND  = 2'd1,
        STATUS_COLLIDE = 2'd2,
        STATUS_FULL    = 2'd3
    } kvt_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_DECIDE
    } kvt_state_t;

    // control from the sequencer to the slot store
    typedef struct packed {
        logic rd;
        logic wr_slot;
        logic wr_value;
        logic set_valid;
    } kvt_store_ctl_t;

endpackage

`default_nettype wire

### rtl/kvt_req_if.sv
// kvt_req_if: insert request channel (valid/ready plus key and value)
// depends on kvt_pkg
`default_nettype none

interface kvt_req_if;
    import kvt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [KEY_W-1:0]        insert_key;
    logic signed [VAL_W-1:0] insert_value;

    modport source (output valid, output insert_key, output insert_value, input ready);
    modport sink (input valid, input insert_key, input insert_value, output ready);
endinterface

`default_nettype wire

### rtl/kvt_rsp_if.sv
// kvt_rsp_if: insert result channel (valid/ready plus status, slot and length)
// depends on kvt_pkg
`default_nettype none

interface kvt_rsp_if;
    import kvt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [LEN_W-1:0]      list_length;

    modport source (output valid, output status, output slot_index, output list_length,
                    input ready);
    modport sink (input valid, input status, input slot_index, input list_length,
                  output ready);
endinterface

`default_nettype wire

### rtl/kvt_mod_unit.sv
// kvt_mod_unit: bit-serial restoring remainder of the key by the table size
// depends on kvt_pkg
`default_nettype none

module kvt_mod_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [kvt_pkg::KEY_W-1:0]  dividend,
    input  wire logic [kvt_pkg::SIZE_W-1:0] divisor,
    output logic                            busy,
    output logic [kvt_pkg::SIZE_W-1:0]      remainder
);
    import kvt_pkg::*;

    localparam int STEP_W = $clog2(KEY_W);

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_next;
    logic [SIZE_W-1:0] div_reg;
    logic [SIZE_W-1:0] div_next;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] rem_next;
    logic [SIZE_W:0]   trial;
    logic              last_step;

    assign trial     = {rem_reg, key_reg[KEY_W-1]};
    assign last_step = (step_reg == STEP_W'(KEY_W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        key_next  = key_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            key_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // partial remainder stays below the divisor, so one subtract suffices
            if (trial >= {1'b0, div_reg})
                rem_next = SIZE_W'(trial - {1'b0, div_reg});
            else
                rem_next = trial[SIZE_W-1:0];
            key_next  = {key_reg[KEY_W-2:0], 1'b0};
            step_next = step_reg + STEP_W'(1);
            if (last_step)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

`ifndef ASSERT_OFF
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (div_reg != '0))
        else $error("divisor is zero while dividing");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> (rem_reg < div_reg))
        else $error("remainder not below divisor at end of division");
`endif

endmodule

`default_nettype wire

### rtl/kvt_store.sv
// kvt_store: slot valid bits, slot key/count memory and value memory
// depends on kvt_pkg
`default_nettype none

module kvt_store #(
    parameter int SLOTS           = kvt_pkg::DEF_SLOTS,
    parameter int VALUES_PER_SLOT = kvt_pkg::DEF_VALUES_PER_SLOT,
    parameter int SLOT_W          = 8,
    parameter int CNT_W           = 5,
    parameter int IDX_W           = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire kvt_pkg::kvt_store_ctl_t    ctl,
    input  wire logic [SLOT_W-1:0]          slot,
    input  wire logic [kvt_pkg::KEY_W-1:0]  wr_key,
    input  wire logic [CNT_W-1:0]           wr_count,
    input  wire logic [IDX_W-1:0]           wr_idx,
    input  wire logic [kvt_pkg::VAL_W-1:0]  wr_value,
    output logic                            rd_valid,
    output logic [kvt_pkg::KEY_W-1:0]       rd_key,
    output logic [CNT_W-1:0]                rd_count
);
    import kvt_pkg::*;

    logic [SLOTS-1:0]       valid_reg;
    logic [KEY_W+CNT_W-1:0] slot_mem [SLOTS];
    logic [VAL_W-1:0]       value_mem [SLOTS][VALUES_PER_SLOT];
    logic                   rd_valid_reg;
    logic [KEY_W+CNT_W-1:0] rd_entry_reg;

    // valid bits, cleared together at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (ctl.set_valid)
            valid_reg[slot] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else if (ctl.rd)
            rd_valid_reg <= valid_reg[slot];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_slot)
            slot_mem[slot] <= {wr_key, wr_count};
        if (ctl.rd)
            rd_entry_reg <= slot_mem[slot];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_value)
            value_mem[slot][wr_idx] <= wr_value;
    end

    assign rd_valid = rd_valid_reg;
    assign rd_key   = rd_entry_reg[KEY_W+CNT_W-1:CNT_W];
    assign rd_count = rd_entry_reg[CNT_W-1:0];

`ifndef ASSERT_OFF
    a_new_slot_written: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.set_valid |-> (ctl.wr_slot && ctl.wr_value))
        else $error("slot marked valid without key and value write");
`endif

endmodule

`default_nettype wire

### rtl/direct_mapped_key_value_table_core.sv
// direct_mapped_key_value_table_core: top level, sequencer, size register, result register
// depends on kvt_pkg, kvt_req_if, kvt_rsp_if, kvt_mod_unit, kvt_store
`default_nettype none

// Direct-mapped key/value table. Each request transfer inserts one key and one
// value into slot (key mod table_size); no probing is done. An empty slot takes
// the key with a list length of one, a slot holding the same key appends the
// value (up to VALUES_PER_SLOT values, then the insert is dropped as full), and
// a slot holding another key drops the insert as a collision. Exactly one result
// transfer follows every request: status, slot and list length after the insert.
// Key 0 is an ordinary key: empty slots are tracked by valid bits that reset
// clears at once, so the table is usable right after reset with no clearing
// pass. table_size is taken 0 as 1 and is capped at SLOTS; change it only while
// the block is idle. Inserts do not overlap: accept in ST_IDLE, the bit-serial
// modulo unit in ST_DIVIDE until the sequencer sees it finish, slot read in
// ST_READ, decide and write-back in ST_DECIDE (held until the result register
// is free); the request side is not ready then. The result sits in an output
// register, so the next request is accepted while a result waits to be taken.

module direct_mapped_key_value_table_core #(
    parameter int SLOTS           = kvt_pkg::DEF_SLOTS,
    parameter int VALUES_PER_SLOT = kvt_pkg::DEF_VALUES_PER_SLOT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [kvt_pkg::SIZE_W-1:0] cfg_wdata,
    kvt_req_if.sink                         req,
    kvt_rsp_if.source                       rsp
);
    import kvt_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(VALUES_PER_SLOT + 1);
    localparam int IDX_W  = (VALUES_PER_SLOT > 1) ? $clog2(VALUES_PER_SLOT) : 1;

    // configuration
    logic [SIZE_W-1:0] table_size_reg;
    logic [SIZE_W-1:0] eff_size;

    // sequencer
    kvt_state_t state_reg;
    kvt_state_t state_next;

    // request payload held for the whole insert
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;

    // modulo unit
    logic              div_start;
    logic              div_busy;
    logic [SIZE_W-1:0] div_rem;
    logic [SLOT_W-1:0] slot;

    // slot store
    kvt_store_ctl_t   store_ctl;
    logic             hit_valid;
    logic [KEY_W-1:0] hit_key;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] wr_count;
    logic [IDX_W-1:0] wr_idx;

    // decision for the current insert
    kvt_status_t      dec_status;
    logic [CNT_W-1:0] dec_len;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    kvt_status_t       status_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0]  len_reg;
    logic              out_free;
    logic              load_out;
    logic              req_fire;

    assign req_fire = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    // table size register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            table_size_reg <= SIZE_RESET;
        else if (cfg_we)
            table_size_reg <= cfg_wdata;
    end

    // zero means one slot, anything above SLOTS is capped
    always_comb
    begin
        eff_size = table_size_reg;
        if (table_size_reg == '0)
            eff_size = SIZE_W'(1);
        else if (int'(table_size_reg) > SLOTS)
            eff_size = SIZE_W'(SLOTS);
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            key_reg   <= req.insert_key;
            value_reg <= req.insert_value;
        end
    end

    kvt_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (req.insert_key),
        .divisor   (eff_size),
        .busy      (div_busy),
        .remainder (div_rem)
    );

    // remainder is below eff_size <= SLOTS, so it fits the slot address
    assign slot = SLOT_W'(div_rem);

    kvt_store #(
        .SLOTS           (SLOTS),
        .VALUES_PER_SLOT (VALUES_PER_SLOT),
        .SLOT_W          (SLOT_W),
        .CNT_W           (CNT_W),
        .IDX_W           (IDX_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (store_ctl),
        .slot     (slot),
        .wr_key   (key_reg),
        .wr_count (wr_count),
        .wr_idx   (wr_idx),
        .wr_value (value_reg),
        .rd_valid (hit_valid),
        .rd_key   (hit_key),
        .rd_count (hit_count)
    );

    // insert decision from the registered slot read
    always_comb
    begin
        dec_status = STATUS_COLLIDE;
        dec_len    = hit_count;
        wr_count   = CNT_W'(1);
        wr_idx     = '0;
        if (!hit_valid)
        begin
            dec_status = STATUS_NEW;
            dec_len    = CNT_W'(1);
        end
        else if (hit_key == key_reg)
        begin
            if (hit_count < CNT_W'(VALUES_PER_SLOT))
            begin
                dec_status = STATUS_APPEND;
                dec_len    = hit_count + CNT_W'(1);
                wr_count   = hit_count + CNT_W'(1);
                wr_idx     = IDX_W'(hit_count);
            end
            else
            begin
                dec_status = STATUS_FULL;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (!div_busy)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // hold here until the result register can take the result
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req.ready = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        store_ctl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                div_start = req.valid;
            end
            ST_DIVIDE:
            begin
            end
            ST_READ:
            begin
                store_ctl.rd = 1'b1;
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (dec_status == STATUS_NEW || dec_status == STATUS_APPEND)
                    begin
                        store_ctl.wr_slot  = 1'b1;
                        store_ctl.wr_value = 1'b1;
                    end
                    store_ctl.set_valid = (dec_status == STATUS_NEW);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // result register, parts the request side from the result side
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg <= dec_status;
            slot_reg   <= slot;
            len_reg    <= dec_len;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.slot_index  = SLOT_IDX_W'(slot_reg);
    assign rsp.list_length = LEN_W'(len_reg);

`ifndef ASSERT_OFF
    a_accept_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |-> !div_busy)
        else $error("request accepted while modulo unit busy");

    a_new_len_one: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && (dec_status == STATUS_NEW) |-> (dec_len == CNT_W'(1)))
        else $error("new slot result with length other than one");

    a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (dec_len <= CNT_W'(VALUES_PER_SLOT)))
        else $error("list length above capacity");
`endif

endmodule

`default_nettype wire
